@@ rtl/core/mbrff_pkg.sv @@
// Shared types, codes and the CRC-16/Modbus byte step for the Modbus RTU
// reply frame finder. No dependencies.
`default_nettype none

package mbrff_pkg;

  // Input item kinds, carried on the slave tuser
  typedef enum logic [1:0] {
    KIND_START   = 2'd0,
    KIND_BYTE    = 2'd1,
    KIND_TIMEOUT = 2'd2
  } kind_e;

  // Result status, carried on the master tuser
  localparam logic STATUS_FRAME = 1'b0;
  localparam logic STATUS_FAIL  = 1'b1;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_LSB  = 16'h0001;

  localparam logic [5:0] ALLOW_RESET = 6'd5;
  localparam int         LEN_MIN     = 4;
  localparam int         CMP_W       = 8;  // wide enough for held and length + allowance

  // One received byte through the reflected CRC-16 register
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if ((c & CRC_LSB) != 16'h0000) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/modbus_rtu_reply_frame_finder.sv @@
// Modbus RTU reply frame finder: receive buffer, window check sequencer with
// a shared byte-wide CRC-16 step, and a registered result stage.
// Depends on mbrff_pkg.
//
//   channel   dir  handshake                    payload
//   s_axis    in   s_axis_tvalid/s_axis_tready  tuser=kind, tdata=byte/expect fields
//   m_axis    out  m_axis_tvalid/m_axis_tready  tuser=status, tdata=frame_byte, tlast
//   cfg       in   cfg_we_i                     cfg_wdata_i=garbage_allowance
//
// Start and timeout transactions are handled in the idle state. A received
// byte runs address, function, CRC over length-2 bytes, trailer, then one
// frame byte out per free result slot when the window passes, stopping early
// on a mismatch; the single store read port makes these steps sequential.
// Reset clears all control state; the byte store holds no reset value.
// A stalled master side holds the sequencer while it emits a result; input
// is taken only when the sequencer is idle and the result register is free.
`default_nettype none

module modbus_rtu_reply_frame_finder #(
  parameter int MAX_FRAME   = 32,
  parameter int STORE_DEPTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic [5:0]  cfg_wdata_i,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // rx_byte[7:0], expect_address[15:8],
                                          // expect_function[23:16], expect_length[29:24]
  input  wire logic [1:0]  s_axis_tuser,  // kind[1:0]
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // frame_byte[7:0]
  output logic             m_axis_tuser,  // status[0]
  output logic             m_axis_tlast
);

  localparam int AW      = $clog2(STORE_DEPTH);
  localparam int CW      = $clog2(STORE_DEPTH + 1);
  localparam int LEN_CAP = (MAX_FRAME < STORE_DEPTH) ? MAX_FRAME : STORE_DEPTH;
  localparam int CMP_W   = mbrff_pkg::CMP_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_ADDR,
    S_FUNC,
    S_CRC,
    S_LO,
    S_HI,
    S_EMIT,
    S_LIMIT
  } state_e;

  state_e state_q, state_d;

  logic [7:0]    byte_store [STORE_DEPTH];
  logic [7:0]    rdata_q;

  logic          hunting_q, hunting_d;
  logic [CW-1:0] held_q, held_d;
  logic [7:0]    want_addr_q, want_addr_d;
  logic [7:0]    want_func_q, want_func_d;
  logic [CW-1:0] want_len_q, want_len_d;
  logic [5:0]    allow_q;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [AW-1:0] start_q, start_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [15:0]   crc_q, crc_d;

  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_byte_q, out_byte_d;
  logic          out_status_q, out_status_d;
  logic          out_last_q, out_last_d;

  logic          out_free;
  logic          in_acc;
  logic          store_wr;
  logic [6:0]    len_raw;
  logic [6:0]    len_sat;
  logic          at_limit;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign store_wr      = in_acc && (s_axis_tuser == mbrff_pkg::KIND_BYTE) && hunting_q &&
                         (held_q < CW'(STORE_DEPTH));

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;

  // Requested length clamped to the supported range
  always_comb begin
    len_raw = {1'b0, s_axis_tdata[29:24]};
    len_sat = len_raw;
    if (len_raw > 7'(LEN_CAP)) begin
      len_sat = 7'(LEN_CAP);
    end
    if (len_raw < 7'(mbrff_pkg::LEN_MIN)) begin
      len_sat = 7'(mbrff_pkg::LEN_MIN);
    end
  end

  // Give-up test once the window is not available or did not match
  assign at_limit = (CMP_W'(held_q) >= (CMP_W'(want_len_q) + CMP_W'(allow_q))) ||
                    (held_q >= CW'(STORE_DEPTH));

  // Byte store: one write port, one registered read port addressed by ptr_d
  always_ff @(posedge clk_i) begin
    if (store_wr) begin
      byte_store[held_q[AW-1:0]] <= s_axis_tdata[7:0];
    end
    rdata_q <= byte_store[ptr_d];
  end

  // Sequencer next state
  always_comb begin
    state_d      = state_q;
    hunting_d    = hunting_q;
    held_d       = held_q;
    want_addr_d  = want_addr_q;
    want_func_d  = want_func_q;
    want_len_d   = want_len_q;
    ptr_d        = ptr_q;
    start_d      = start_q;
    cnt_d        = cnt_q;
    crc_d        = crc_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_byte_d   = out_byte_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (s_axis_tuser)
            mbrff_pkg::KIND_START: begin
              want_addr_d = s_axis_tdata[15:8];
              want_func_d = s_axis_tdata[23:16];
              want_len_d  = CW'(len_sat);
              held_d      = '0;
              hunting_d   = 1'b1;
            end
            mbrff_pkg::KIND_BYTE: begin
              if (hunting_q) begin
                if (held_q < CW'(STORE_DEPTH)) begin
                  held_d = held_q + CW'(1);
                end
                state_d = S_CHECK;
              end
            end
            mbrff_pkg::KIND_TIMEOUT: begin
              if (hunting_q) begin
                hunting_d    = 1'b0;
                out_valid_d  = 1'b1;
                out_status_d = mbrff_pkg::STATUS_FAIL;
                out_byte_d   = 8'h00;
                out_last_d   = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Window available: point at its first byte; else go to the give-up test
      S_CHECK: begin
        if (held_q >= want_len_q) begin
          start_d = AW'(held_q - want_len_q);
          ptr_d   = AW'(held_q - want_len_q);
          state_d = S_ADDR;
        end else begin
          state_d = S_LIMIT;
        end
      end

      S_ADDR: begin
        if (rdata_q == want_addr_q) begin
          ptr_d   = ptr_q + AW'(1);
          state_d = S_FUNC;
        end else begin
          state_d = S_LIMIT;
        end
      end

      S_FUNC: begin
        if (rdata_q == want_func_q) begin
          ptr_d   = start_q;
          crc_d   = mbrff_pkg::CRC_INIT;
          cnt_d   = want_len_q - CW'(2);
          state_d = S_CRC;
        end else begin
          state_d = S_LIMIT;
        end
      end

      // One byte per cycle through the shared CRC step
      S_CRC: begin
        crc_d = mbrff_pkg::crc16_byte(crc_q, rdata_q);
        ptr_d = ptr_q + AW'(1);
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          state_d = S_LO;
        end
      end

      S_LO: begin
        if (rdata_q == crc_q[7:0]) begin
          ptr_d   = ptr_q + AW'(1);
          state_d = S_HI;
        end else begin
          state_d = S_LIMIT;
        end
      end

      S_HI: begin
        if (rdata_q == crc_q[15:8]) begin
          ptr_d   = start_q;
          cnt_d   = want_len_q;
          state_d = S_EMIT;
        end else begin
          state_d = S_LIMIT;
        end
      end

      // Frame bytes out, one per free result slot
      S_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = mbrff_pkg::STATUS_FRAME;
          out_byte_d   = rdata_q;
          out_last_d   = (cnt_q == CW'(1));
          ptr_d        = ptr_q + AW'(1);
          cnt_d        = cnt_q - CW'(1);
          if (cnt_q == CW'(1)) begin
            hunting_d = 1'b0;
            state_d   = S_IDLE;
          end
        end
      end

      S_LIMIT: begin
        if (!at_limit) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = mbrff_pkg::STATUS_FAIL;
          out_byte_d   = 8'h00;
          out_last_d   = 1'b1;
          hunting_d    = 1'b0;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State, control and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      hunting_q    <= 1'b0;
      held_q       <= '0;
      want_addr_q  <= 8'h00;
      want_func_q  <= 8'h00;
      want_len_q   <= CW'(mbrff_pkg::LEN_MIN);
      allow_q      <= mbrff_pkg::ALLOW_RESET;
      ptr_q        <= '0;
      start_q      <= '0;
      cnt_q        <= '0;
      crc_q        <= mbrff_pkg::CRC_INIT;
      out_valid_q  <= 1'b0;
      out_byte_q   <= 8'h00;
      out_status_q <= mbrff_pkg::STATUS_FRAME;
      out_last_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      hunting_q    <= hunting_d;
      held_q       <= held_d;
      want_addr_q  <= want_addr_d;
      want_func_q  <= want_func_d;
      want_len_q   <= want_len_d;
      if (cfg_we_i) begin
        allow_q <= cfg_wdata_i;
      end
      ptr_q        <= ptr_d;
      start_q      <= start_d;
      cnt_q        <= cnt_d;
      crc_q        <= crc_d;
      out_valid_q  <= out_valid_d;
      out_byte_q   <= out_byte_d;
      out_status_q <= out_status_d;
      out_last_q   <= out_last_d;
    end
  end

  // Checks on the sequencer
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CW'(STORE_DEPTH))
    else $error("bytes held beyond store depth");

  a_busy_hunting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> hunting_q)
    else $error("sequencer busy while not hunting");

  a_emit_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && out_free && cnt_q == CW'(1)) |=>
      (!hunting_q && m_axis_tvalid && m_axis_tlast && state_q == S_IDLE))
    else $error("frame run did not end cleanly");

  a_fail_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == mbrff_pkg::STATUS_FAIL) |->
      (m_axis_tlast && m_axis_tdata == 8'h00))
    else $error("failure result malformed");

endmodule

`default_nettype wire
